### src/drk4_pkg.sv
package drk4_pkg;

	// Fixed-point format of the state and of every intermediate value.
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Division by six: n / 6 == (n * ceil(2^34 / 6)) >> 34 for any n below 2^32.
	localparam int                         DIV_SHIFT = 34;
	localparam logic signed [DATA_WIDTH:0] RECIP6    = 33'h0_AAAA_AAAB;

	// Configuration registers.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int STEP_W     = 17;
	localparam int COEF_W     = 20;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUBIC_COEFF   = 2'd2;

	localparam logic [STEP_W-1:0] STEP_SIZE_RST     = 17'd655;
	localparam logic [COEF_W-1:0] DAMPING_RATIO_RST = 20'd3277;
	localparam logic [COEF_W-1:0] CUBIC_COEFF_RST   = 20'd65536;

	typedef struct packed {
		logic signed [31:0] force_sample;
		logic               run_start;
		logic               clear_extremes;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] disp;
		logic signed [31:0] vel;
		logic signed [31:0] disp_low;
		logic signed [31:0] disp_high;
		logic signed [31:0] vel_low;
		logic signed [31:0] vel_high;
		logic               saturated;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_MULWB,
		OP_DIV,
		OP_DIVWB
	} alu_op_t;

	typedef enum logic [3:0] {
		SRC_ZERO,
		SRC_Y1,
		SRC_Y2,
		SRC_P,
		SRC_Q,
		SRC_T,
		SRC_U,
		SRC_R,
		SRC_AK,
		SRC_VK,
		SRC_SA,
		SRC_SV,
		SRC_F,
		SRC_DT,
		SRC_TZ,
		SRC_EPS
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_Y1,
		DST_Y2,
		DST_P,
		DST_Q,
		DST_T,
		DST_U,
		DST_R,
		DST_AK,
		DST_VK,
		DST_SA,
		DST_SV
	} dst_t;

	typedef struct packed {
		alu_op_t op;
		src_t    src_a;
		src_t    src_b;
		logic    half_b;
		dst_t    dst;
	} uop_t;

	typedef struct packed {
		uop_t uop;
		logic idle;
		logic finish;
	} seq_ctl_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CUBE1,
		ST_CUBE1W,
		ST_CUBE2,
		ST_CUBE2W,
		ST_EPS,
		ST_EPSW,
		ST_DAMP,
		ST_DAMPW,
		ST_R1,
		ST_R2,
		ST_R3,
		ST_VK,
		ST_VKW,
		ST_AK,
		ST_AKW,
		ST_ACC,
		ST_DIVA,
		ST_DIVAW,
		ST_UPDA,
		ST_DIVV,
		ST_DIVVW,
		ST_UPDV,
		ST_DONE
	} seq_state_t;

endpackage

### src/duffing_rk4_step.sv
// An input beat is taken only while the sequencer is idle, so a step is finished before the
// next beat is taken, and a full output register holds the finished step back. Steps are
// serialised by the single shared multiplier and adder, which serve 24 products, 2 divisions
// by six and the saturating sums of the four Runge-Kutta stages one after another.
// Reset: arst_n clears state, the extreme trackers and the handshakes at once, and loads
// the step size, damping ratio and cubic coefficient with their default values.
module duffing_rk4_step import drk4_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	// Configuration registers, to be written only while the block is idle; no check.
	logic [STEP_W-1:0] step_q;
	logic [COEF_W-1:0] damp_q;
	logic [COEF_W-1:0] cubic_q;

	// Architectural state: displacement, velocity and the four extreme trackers.
	logic signed [DATA_WIDTH-1:0] y1_q, y2_q;
	logic signed [DATA_WIDTH-1:0] dmin_q, dmax_q, vmin_q, vmax_q;

	// Working registers of one step. P and Q hold the arguments of the current stage,
	// T and U are scratch, R builds the acceleration, AK and VK are the stage
	// increments and SA and SV the weighted sums.
	logic signed [DATA_WIDTH-1:0] f_q, p_q, q_q, t_q, u_q, r_q;
	logic signed [DATA_WIDTH-1:0] ak_q, vk_q, sa_q, sv_q;
	logic                         sat_q;

	out_item_t out_q;
	logic      out_valid_q;

	seq_ctl_t                     seq_ctl;
	logic                         accept;
	logic                         out_free;
	logic signed [DATA_WIDTH-1:0] dt, tz, eps;
	logic signed [DATA_WIDTH-1:0] opa, opb_raw, opb;
	logic signed [DATA_WIDTH-1:0] alu_res;
	logic                         alu_sat;
	logic signed [DATA_WIDTH-1:0] dmin_d, dmax_d, vmin_d, vmax_d;

	assign accept   = in_valid && in_ready;
	assign in_ready = seq_ctl.idle;
	// The output register may be refilled in the very cycle its beat is taken.
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The registers are narrow and unsigned, so none of them can reach the clip limits;
	// doubling the damping ratio needs only one extra bit.
	assign dt  = DATA_WIDTH'(step_q);
	assign tz  = DATA_WIDTH'({damp_q, 1'b0});
	assign eps = DATA_WIDTH'(cubic_q);

	drk4_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.out_free (out_free),
		.ctl      (seq_ctl)
	);

	// Operand selection for the shared unit.
	function automatic logic signed [DATA_WIDTH-1:0] pick(
		src_t                         s,
		logic signed [DATA_WIDTH-1:0] y1, y2, p, q, t, u, r, ak, vk, sa, sv, f,
		logic signed [DATA_WIDTH-1:0] cdt, ctz, ceps
	);
		logic signed [DATA_WIDTH-1:0] v;
		case (s)
			SRC_Y1:  v = y1;
			SRC_Y2:  v = y2;
			SRC_P:   v = p;
			SRC_Q:   v = q;
			SRC_T:   v = t;
			SRC_U:   v = u;
			SRC_R:   v = r;
			SRC_AK:  v = ak;
			SRC_VK:  v = vk;
			SRC_SA:  v = sa;
			SRC_SV:  v = sv;
			SRC_F:   v = f;
			SRC_DT:  v = cdt;
			SRC_TZ:  v = ctz;
			SRC_EPS: v = ceps;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa     = pick(seq_ctl.uop.src_a, y1_q, y2_q, p_q, q_q, t_q, u_q, r_q,
			ak_q, vk_q, sa_q, sv_q, f_q, dt, tz, eps);
		opb_raw = pick(seq_ctl.uop.src_b, y1_q, y2_q, p_q, q_q, t_q, u_q, r_q,
			ak_q, vk_q, sa_q, sv_q, f_q, dt, tz, eps);
		// Halving is an arithmetic shift right by one, applied before the add.
		opb     = seq_ctl.uop.half_b ? (opb_raw >>> 1) : opb_raw;
	end

	drk4_alu u_alu (
		.clk    (clk),
		.op     (seq_ctl.uop.op),
		.a      (opa),
		.b      (opb),
		.result (alu_res),
		.sat    (alu_sat)
	);

	// The trackers take the new state as it leaves for the output register.
	always_comb begin
		dmin_d = (y1_q < dmin_q) ? y1_q : dmin_q;
		dmax_d = (y1_q > dmax_q) ? y1_q : dmax_q;
		vmin_d = (y2_q < vmin_q) ? y2_q : vmin_q;
		vmax_d = (y2_q > vmax_q) ? y2_q : vmax_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= STEP_SIZE_RST;
			damp_q  <= DAMPING_RATIO_RST;
			cubic_q <= CUBIC_COEFF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STEP_SIZE:     step_q  <= cfg_wdata[STEP_W-1:0];
				REG_DAMPING_RATIO: damp_q  <= cfg_wdata[COEF_W-1:0];
				REG_CUBIC_COEFF:   cubic_q <= cfg_wdata[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// State, trackers, clip flag and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q        <= '0;
			y2_q        <= '0;
			dmin_q      <= MAXV;
			dmax_q      <= MINV;
			vmin_q      <= MAXV;
			vmax_q      <= MINV;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				sat_q <= 1'b0;
				if (in_data.run_start) begin
					y1_q <= '0;
					y2_q <= '0;
				end
				if (in_data.clear_extremes) begin
					dmin_q <= MAXV;
					dmax_q <= MINV;
					vmin_q <= MAXV;
					vmax_q <= MINV;
				end
			end else if (seq_ctl.uop.dst != DST_NONE) begin
				sat_q <= sat_q | alu_sat;
				if (seq_ctl.uop.dst == DST_Y1) begin
					y1_q <= alu_res;
				end
				if (seq_ctl.uop.dst == DST_Y2) begin
					y2_q <= alu_res;
				end
			end
			if (seq_ctl.finish) begin
				dmin_q      <= dmin_d;
				dmax_q      <= dmax_d;
				vmin_q      <= vmin_d;
				vmax_q      <= vmax_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers need no reset: each is written before it is read in a step.
	always_ff @(posedge clk) begin
		if (accept) begin
			f_q <= in_data.force_sample;
			p_q <= in_data.run_start ? '0 : y1_q;
			q_q <= in_data.run_start ? '0 : y2_q;
		end else begin
			case (seq_ctl.uop.dst)
				DST_P:   p_q  <= alu_res;
				DST_Q:   q_q  <= alu_res;
				DST_T:   t_q  <= alu_res;
				DST_U:   u_q  <= alu_res;
				DST_R:   r_q  <= alu_res;
				DST_AK:  ak_q <= alu_res;
				DST_VK:  vk_q <= alu_res;
				DST_SA:  sa_q <= alu_res;
				DST_SV:  sv_q <= alu_res;
				default: begin
				end
			endcase
		end
		if (seq_ctl.finish) begin
			out_q.disp      <= y1_q;
			out_q.vel       <= y2_q;
			out_q.disp_low  <= dmin_d;
			out_q.disp_high <= dmax_d;
			out_q.vel_low   <= vmin_d;
			out_q.vel_high  <= vmax_d;
			out_q.saturated <= sat_q;
		end
	end

	// A result beat appears only when the sequencer has finished a step.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(seq_ctl.finish))
		else $error("result beat raised without a finished step");

	// Once an input beat is taken the sequencer is busy for the whole step.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !seq_ctl.idle)
		else $error("sequencer idle right after an input beat");

	// The reported extremes always bracket the reported state.
	a_disp_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.disp_low <= out_data.disp)
			&& (out_data.disp <= out_data.disp_high))
		else $error("displacement outside its reported extremes");

	a_vel_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.vel_low <= out_data.vel)
			&& (out_data.vel <= out_data.vel_high))
		else $error("velocity outside its reported extremes");

endmodule

### src/drk4_alu.sv
module drk4_alu import drk4_pkg::*; (
	input  logic                         clk,
	input  alu_op_t                      op,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic signed [DATA_WIDTH-1:0] result,
	output logic                         sat
);

	localparam int MW = DATA_WIDTH + 1;
	localparam int PW = 2 * MW;

	logic signed [MW-1:0]         a_ext, b_ext, a_mag, mul_a, mul_b;
	logic signed [PW-1:0]         prod_s1, prod_shr;
	logic                         neg_s1;
	logic                         mul_ovf;
	logic signed [MW-1:0]         sum;
	logic [DATA_WIDTH-1:0]        quot;
	logic [PW-DATA_WIDTH:0]       prod_hi;

	always_comb begin
		a_ext = {a[DATA_WIDTH-1], a};
		b_ext = {b[DATA_WIDTH-1], b};
		a_mag = a[DATA_WIDTH-1] ? -a_ext : a_ext;
		mul_a = (op == OP_DIV) ? a_mag : a_ext;
		mul_b = (op == OP_DIV) ? RECIP6 : b_ext;
	end

	// The product register splits the multiplier from the scaling and clipping.
	always_ff @(posedge clk) begin
		if (op == OP_MUL || op == OP_DIV) begin
			prod_s1 <= mul_a * mul_b;
			neg_s1  <= a[DATA_WIDTH-1];
		end
	end

	always_comb begin
		prod_shr = prod_s1 >>> FRAC_BITS;
		prod_hi  = prod_shr[PW-1:DATA_WIDTH-1];
		mul_ovf  = !((&prod_hi) || !(|prod_hi));
		quot     = prod_s1[DIV_SHIFT +: DATA_WIDTH];
		sum      = '0;
		result   = '0;
		sat      = 1'b0;
		case (op)
			OP_ADD, OP_SUB: begin
				sum = (op == OP_ADD) ? (a_ext + b_ext) : (a_ext - b_ext);
				sat = sum[MW-1] != sum[MW-2];
				if (sat) begin
					result = sum[MW-1] ? MINV : MAXV;
				end else begin
					result = sum[DATA_WIDTH-1:0];
				end
			end
			OP_MULWB: begin
				sat = mul_ovf;
				if (mul_ovf) begin
					result = prod_s1[PW-1] ? MINV : MAXV;
				end else begin
					result = prod_shr[DATA_WIDTH-1:0];
				end
			end
			OP_DIVWB: begin
				result = neg_s1 ? -quot : quot;
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

### src/drk4_seq.sv
module drk4_seq import drk4_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     out_free,
	output seq_ctl_t ctl
);

	localparam logic [1:0] LAST_STAGE = 2'd3;

	seq_state_t state_q, state_d;
	logic [1:0] stage_q;
	logic [2:0] sub_q;
	logic       acc_last;
	uop_t       acc_uop;

	function automatic uop_t mk(alu_op_t op, src_t sa, src_t sb, logic h, dst_t d);
		uop_t u;
		u.op     = op;
		u.src_a  = sa;
		u.src_b  = sb;
		u.half_b = h;
		u.dst    = d;
		return u;
	endfunction

	// Accumulation of the weighted sums and, in all but the last stage, the arguments of the next stage.
	always_comb begin
		acc_uop  = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
		acc_last = 1'b0;
		case (stage_q)
			2'd0: begin
				acc_last = sub_q == 3'd3;
				case (sub_q)
					3'd0: acc_uop = mk(OP_ADD, SRC_AK, SRC_ZERO, 1'b0, DST_SA);
					3'd1: acc_uop = mk(OP_ADD, SRC_VK, SRC_ZERO, 1'b0, DST_SV);
					3'd2: acc_uop = mk(OP_ADD, SRC_Y1, SRC_AK, 1'b1, DST_P);
					3'd3: acc_uop = mk(OP_ADD, SRC_Y2, SRC_VK, 1'b1, DST_Q);
					default: acc_uop = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
				endcase
			end
			2'd1: begin
				acc_last = sub_q == 3'd5;
				case (sub_q)
					3'd0, 3'd1: acc_uop = mk(OP_ADD, SRC_SA, SRC_AK, 1'b0, DST_SA);
					3'd2, 3'd3: acc_uop = mk(OP_ADD, SRC_SV, SRC_VK, 1'b0, DST_SV);
					3'd4: acc_uop = mk(OP_ADD, SRC_Y1, SRC_AK, 1'b1, DST_P);
					3'd5: acc_uop = mk(OP_ADD, SRC_Y2, SRC_VK, 1'b1, DST_Q);
					default: acc_uop = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
				endcase
			end
			2'd2: begin
				acc_last = sub_q == 3'd5;
				case (sub_q)
					3'd0: acc_uop = mk(OP_ADD, SRC_AK, SRC_AK, 1'b0, DST_T);
					3'd1: acc_uop = mk(OP_ADD, SRC_SA, SRC_T, 1'b0, DST_SA);
					3'd2: acc_uop = mk(OP_ADD, SRC_VK, SRC_VK, 1'b0, DST_T);
					3'd3: acc_uop = mk(OP_ADD, SRC_SV, SRC_T, 1'b0, DST_SV);
					3'd4: acc_uop = mk(OP_ADD, SRC_Y1, SRC_AK, 1'b0, DST_P);
					3'd5: acc_uop = mk(OP_ADD, SRC_Y2, SRC_VK, 1'b0, DST_Q);
					default: acc_uop = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
				endcase
			end
			default: begin
				acc_last = sub_q == 3'd1;
				case (sub_q)
					3'd0: acc_uop = mk(OP_ADD, SRC_SA, SRC_AK, 1'b0, DST_SA);
					3'd1: acc_uop = mk(OP_ADD, SRC_SV, SRC_VK, 1'b0, DST_SV);
					default: acc_uop = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= '0;
			sub_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC) begin
				sub_q <= acc_last ? 3'd0 : sub_q + 3'd1;
				if (acc_last) begin
					stage_q <= stage_q + 2'd1;
				end
			end else begin
				sub_q <= '0;
			end
			if (state_q == ST_IDLE && start) begin
				stage_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_CUBE1;
			ST_CUBE1:  state_d = ST_CUBE1W;
			ST_CUBE1W: state_d = ST_CUBE2;
			ST_CUBE2:  state_d = ST_CUBE2W;
			ST_CUBE2W: state_d = ST_EPS;
			ST_EPS:    state_d = ST_EPSW;
			ST_EPSW:   state_d = ST_DAMP;
			ST_DAMP:   state_d = ST_DAMPW;
			ST_DAMPW:  state_d = ST_R1;
			ST_R1:     state_d = ST_R2;
			ST_R2:     state_d = ST_R3;
			ST_R3:     state_d = ST_VK;
			ST_VK:     state_d = ST_VKW;
			ST_VKW:    state_d = ST_AK;
			ST_AK:     state_d = ST_AKW;
			ST_AKW:    state_d = ST_ACC;
			ST_ACC: begin
				if (acc_last) begin
					state_d = (stage_q == LAST_STAGE) ? ST_DIVA : ST_CUBE1;
				end
			end
			ST_DIVA:   state_d = ST_DIVAW;
			ST_DIVAW:  state_d = ST_UPDA;
			ST_UPDA:   state_d = ST_DIVV;
			ST_DIVV:   state_d = ST_DIVVW;
			ST_DIVVW:  state_d = ST_UPDV;
			ST_UPDV:   state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.uop    = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
		ctl.idle   = state_q == ST_IDLE;
		ctl.finish = (state_q == ST_DONE) && out_free;
		case (state_q)
			ST_CUBE1:  ctl.uop = mk(OP_MUL, SRC_P, SRC_P, 1'b0, DST_NONE);
			ST_CUBE1W: ctl.uop = mk(OP_MULWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_T);
			ST_CUBE2:  ctl.uop = mk(OP_MUL, SRC_T, SRC_P, 1'b0, DST_NONE);
			ST_CUBE2W: ctl.uop = mk(OP_MULWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_T);
			ST_EPS:    ctl.uop = mk(OP_MUL, SRC_EPS, SRC_T, 1'b0, DST_NONE);
			ST_EPSW:   ctl.uop = mk(OP_MULWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_U);
			ST_DAMP:   ctl.uop = mk(OP_MUL, SRC_TZ, SRC_Q, 1'b0, DST_NONE);
			ST_DAMPW:  ctl.uop = mk(OP_MULWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_R);
			ST_R1:     ctl.uop = mk(OP_SUB, SRC_F, SRC_R, 1'b0, DST_R);
			ST_R2:     ctl.uop = mk(OP_SUB, SRC_R, SRC_P, 1'b0, DST_R);
			ST_R3:     ctl.uop = mk(OP_SUB, SRC_R, SRC_U, 1'b0, DST_R);
			ST_VK:     ctl.uop = mk(OP_MUL, SRC_DT, SRC_R, 1'b0, DST_NONE);
			ST_VKW:    ctl.uop = mk(OP_MULWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_VK);
			ST_AK:     ctl.uop = mk(OP_MUL, SRC_DT, SRC_Q, 1'b0, DST_NONE);
			ST_AKW:    ctl.uop = mk(OP_MULWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_AK);
			ST_ACC:    ctl.uop = acc_uop;
			ST_DIVA:   ctl.uop = mk(OP_DIV, SRC_SA, SRC_ZERO, 1'b0, DST_NONE);
			ST_DIVAW:  ctl.uop = mk(OP_DIVWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_T);
			ST_UPDA:   ctl.uop = mk(OP_ADD, SRC_Y1, SRC_T, 1'b0, DST_Y1);
			ST_DIVV:   ctl.uop = mk(OP_DIV, SRC_SV, SRC_ZERO, 1'b0, DST_NONE);
			ST_DIVVW:  ctl.uop = mk(OP_DIVWB, SRC_ZERO, SRC_ZERO, 1'b0, DST_T);
			ST_UPDV:   ctl.uop = mk(OP_ADD, SRC_Y2, SRC_T, 1'b0, DST_Y2);
			default:   ctl.uop = mk(OP_NOP, SRC_ZERO, SRC_ZERO, 1'b0, DST_NONE);
		endcase
	end

endmodule
